>>> hw/rtl/tach_pkg.sv
// ----------------------------------------------------------------------------
// tach_pkg
// Shared widths, reset values, register indexes and controller states of the
// tachometer rate counter.
// ----------------------------------------------------------------------------
package tach_pkg;

    // Default parameter values
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int THR_W       = 10;
    localparam int SCALE_W     = 16;
    localparam int RATE_W      = 16;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 5;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int DIG_IDX_W   = 3;
    localparam int STEP_W      = $clog2(RATE_W);
    localparam int OUT_TDATA_W = ((RATE_W + DIGIT_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]   PULSE_THR_RST  = 10'd600;
    localparam logic [THR_W-1:0]   STOP_THR_RST   = 10'd950;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 16'd60;

    // Largest decimal digit, double-dabble adjust threshold and offset
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [DIGIT_W-1:0] DABBLE_THR = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_DIV,
        ST_BCD,
        ST_EMIT,
        ST_HALT
    } tach_state_t;

endpackage

>>> hw/rtl/tach_mul.sv
// ----------------------------------------------------------------------------
// tach_mul
// Bit-serial shift-add multiplier: pulse count times rate scale, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tach_mul
    import tach_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [COUNT_WIDTH-1:0]         multiplicand,
    input  logic [SCALE_W-1:0]             multiplier,
    output logic                           done,
    output logic [COUNT_WIDTH+SCALE_W-1:0] product
);

    localparam int PROD_W = COUNT_WIDTH + SCALE_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [SCALE_W-1:0] mplier_reg, mplier_next;
    logic [PROD_W-1:0] acc_reg, acc_next;

    // Next-state logic: add shifted multiplicand when the multiplier LSB is set
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            step_next   = STEP_W'(RATE_W - 1);
            mcand_next  = PROD_W'(multiplicand);
            mplier_next = multiplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[SCALE_W-1:1]};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> hw/rtl/tach_div.sv
// ----------------------------------------------------------------------------
// tach_div
// Restoring radix-2 divider: one quotient bit per cycle. The quotient is
// known to fit RATE_W bits, so the high dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module tach_div
    import tach_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [COUNT_WIDTH+SCALE_W-1:0] dividend,
    input  logic [COUNT_WIDTH-1:0]         divisor,
    output logic                           done,
    output logic [RATE_W-1:0]              quotient
);

    localparam int PROD_W = COUNT_WIDTH + SCALE_W;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0]      low_reg, low_next;
    logic [RATE_W-1:0]      quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] dsor_reg, dsor_next;
    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH+1:0] trial;

    // Trial subtraction of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, low_reg[RATE_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsor_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dsor_next = dsor_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RATE_W - 1);
            rem_next  = dividend[PROD_W-1:RATE_W];
            low_next  = dividend[RATE_W-1:0];
            quo_next  = '0;
            dsor_next = divisor;
        end
        else if (busy_reg)
        begin
            low_next = {low_reg[RATE_W-2:0], 1'b0};
            if (!trial[COUNT_WIDTH+1])
            begin
                rem_next = trial[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[RATE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[COUNT_WIDTH-1:0];
                quo_next = {quo_reg[RATE_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/tach_bcd.sv
// ----------------------------------------------------------------------------
// tach_bcd
// Serial double-dabble converter: shifts the binary rate in one bit per
// cycle, adjusting each BCD digit before the shift.
// ----------------------------------------------------------------------------
module tach_bcd
    import tach_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RATE_W-1:0] bin,
    output logic              done,
    output logic [BCD_W-1:0]  bcd
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RATE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  adj;

    // Add three to every digit of five or more
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= DABBLE_THR)
            begin
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end
            else
            begin
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RATE_W - 1);
            bin_next  = bin;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[RATE_W-1]};
            bin_next = {bin_reg[RATE_W-2:0], 1'b0};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> hw/rtl/tachometer_rpm_with_decimal_digits_top.sv
// A running tick passes the serial multiplier, serial divider and BCD shifter,
// then gives one beat per decimal digit (1 to 5 digits) as the sink takes them.
// A tick that halts, or arrives while halted, gives its one result via ST_HALT.
// The next tick is accepted once the last digit is in the output register.
// Reset (rst_n, asynchronous) clears counts and halt, restores register defaults.
// ----------------------------------------------------------------------------
// tachometer_rpm_with_decimal_digits_top
// Counts ticks and pulse ticks until a stop sample crosses its threshold; each
// counted tick reports rate = pulses * scale / ticks as decimal digits, MSD first.
// ----------------------------------------------------------------------------
module tachometer_rpm_with_decimal_digits_top
    import tach_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // tdata: sense_sample, stop_sample (zero padded to bytes)
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: rate_value, decimal_digit (zero padded to bytes)
    output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,
    // tuser: halted_flag
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data
);

    localparam int CMP_W     = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int PROD_W    = COUNT_WIDTH + SCALE_W;
    localparam int OUT_PAD_W = OUT_TDATA_W - RATE_W - DIGIT_W;

    tach_state_t state_reg, state_next;

    logic [THR_W-1:0]       pulse_thr_reg;
    logic [THR_W-1:0]       stop_thr_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [COUNT_WIDTH-1:0] pulse_cnt_reg;
    logic [COUNT_WIDTH-1:0] tick_cnt_reg;
    logic                   halted_reg;
    logic [DIG_IDX_W-1:0]   dig_idx_reg, dig_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]      out_rate_reg, out_rate_next;
    logic [DIGIT_W-1:0]     out_digit_reg, out_digit_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_halt_reg, out_halt_next;

    logic                   in_xact;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] sense;
    logic [SAMPLE_BITS-1:0] stop;
    logic                   stop_hit;
    logic                   pulse_hit;

    logic                   mul_start, mul_done;
    logic                   div_start, div_done;
    logic                   bcd_start, bcd_done;
    logic [PROD_W-1:0]      product;
    logic [RATE_W-1:0]      rate;
    logic [BCD_W-1:0]       bcd;
    logic [DIG_IDX_W-1:0]   msd_idx;

    // Input decode and threshold compares
    assign sense     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign stop      = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign stop_hit  = CMP_W'(stop) > CMP_W'(stop_thr_reg);
    assign pulse_hit = CMP_W'(sense) > CMP_W'(pulse_thr_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_thr_reg <= PULSE_THR_RST;
            stop_thr_reg  <= STOP_THR_RST;
            scale_reg     <= RATE_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PULSE_THR:  pulse_thr_reg <= cfg_data[THR_W-1:0];
                REG_STOP_THR:   stop_thr_reg  <= cfg_data[THR_W-1:0];
                REG_RATE_SCALE: scale_reg     <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Saturating tick and pulse counters, sticky halt
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_cnt_reg <= '0;
            tick_cnt_reg  <= '0;
            halted_reg    <= 1'b0;
        end
        else if (in_xact)
        begin
            if (halted_reg || stop_hit)
            begin
                halted_reg <= 1'b1;
            end
            else
            begin
                if (tick_cnt_reg != '1)
                begin
                    tick_cnt_reg <= tick_cnt_reg + 1'b1;
                end
                if (pulse_hit && (pulse_cnt_reg != '1))
                begin
                    pulse_cnt_reg <= pulse_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Serial arithmetic chain
    tach_mul #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (pulse_cnt_reg),
        .multiplier   (scale_reg),
        .done         (mul_done),
        .product      (product)
    );

    tach_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (tick_cnt_reg),
        .done     (div_done),
        .quotient (rate)
    );

    tach_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .bin   (rate),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    // Index of the most significant nonzero digit; zero rate gives one digit
    always_comb
    begin
        msd_idx = '0;
        for (int k = 1; k < NUM_DIGITS; k++)
        begin
            if (bcd[k*DIGIT_W +: DIGIT_W] != '0)
            begin
                msd_idx = DIG_IDX_W'(k);
            end
        end
    end

    // Controller: next state and output register loads
    always_comb
    begin
        state_next     = state_reg;
        dig_idx_next   = dig_idx_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        bcd_start      = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_rate_next  = out_rate_reg;
        out_digit_next = out_digit_reg;
        out_last_next  = out_last_reg;
        out_halt_next  = out_halt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    if (halted_reg || stop_hit)
                    begin
                        state_next = ST_HALT;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    bcd_start  = 1'b1;
                    state_next = ST_BCD;
                end
            end
            ST_BCD:
            begin
                if (bcd_done)
                begin
                    dig_idx_next = msd_idx;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = rate;
                    out_digit_next = bcd[dig_idx_reg*DIGIT_W +: DIGIT_W];
                    out_last_next  = (dig_idx_reg == '0);
                    out_halt_next  = 1'b0;
                    if (dig_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_idx_next = dig_idx_reg - 1'b1;
                    end
                end
            end
            ST_HALT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = '0;
                    out_digit_next = '0;
                    out_last_next  = 1'b1;
                    out_halt_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dig_idx_reg   <= dig_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        out_rate_reg  <= out_rate_next;
        out_digit_reg <= out_digit_next;
        out_last_reg  <= out_last_next;
        out_halt_reg  <= out_halt_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_digit_reg, out_rate_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_halt_reg;

    // Checks
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared while out of reset");

    a_pulse_le_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_cnt_reg <= tick_cnt_reg)
        else $error("pulse count exceeds tick count");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_digit_reg <= DIGIT_MAX))
        else $error("decimal digit out of range");

    a_halt_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_halt_reg) |->
            (out_last_reg && (out_rate_reg == '0) && (out_digit_reg == '0)))
        else $error("halted result carries nonzero payload");

    a_rate_le_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rate <= scale_reg))
        else $error("rate exceeds scale");

endmodule
